// ===== design/slms_pkg.sv =====
package slms_pkg;

    // item codes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_SCROLL_LENGTH,
        REG_SHOW_WIDTH,
        REG_FRAMES_PER_STEP,
        REG_HOLD_TICKS
    } reg_index_t;

    localparam int CFG_DATA_W = 16;

    // reset values of the registers
    localparam logic [6:0]  SCROLL_LENGTH_RST   = 7'd64;
    localparam logic [6:0]  SHOW_WIDTH_RST      = 7'd32;
    localparam logic [7:0]  FRAMES_PER_STEP_RST = 8'd40;
    localparam logic [15:0] HOLD_TICKS_RST      = 16'd1000;

    localparam logic [3:0] LAST_BIT = 4'd15;
    localparam logic [1:0] LAST_ROW = 2'd3;

    typedef struct packed {
        logic [6:0]  scroll_length;
        logic [6:0]  show_width;
        logic [7:0]  frames_per_step;
        logic [15:0] hold_ticks;
    } cfg_t;

    // pin state of one tick, before the pixel bits are picked
    typedef struct packed {
        logic [1:0] row_address;
        logic       shift;
        logic [3:0] bit_idx;
        logic       shift_clock;
        logic       latch;
        logic       output_blank;
        logic       frame_end;
    } scan_out_t;

endpackage

// ===== design/slms_in_if.sv =====
interface slms_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [3:0] buf_row;
    logic [5:0] buf_column;
    logic [7:0] buf_data;

    modport source (output valid, output mode, output buf_row, output buf_column,
                    output buf_data, input ready);
    modport sink   (input valid, input mode, input buf_row, input buf_column,
                    input buf_data, output ready);
endinterface

// ===== design/slms_out_if.sv =====
interface slms_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] row_address;
    logic       upper_red;
    logic       lower_red;
    logic       shift_clock;
    logic       latch;
    logic       output_blank;
    logic       frame_end;

    modport source (output valid, output row_address, output upper_red,
                    output lower_red, output shift_clock, output latch,
                    output output_blank, output frame_end, input ready);
    modport sink   (input valid, input row_address, input upper_red,
                    input lower_red, input shift_clock, input latch,
                    input output_blank, input frame_end, output ready);
endinterface

// ===== design/slms_frame_buf.sv =====
module slms_frame_buf #(
    parameter int MAX_COLUMNS = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [$clog2(MAX_COLUMNS)+1:0]    wr_addr,
    input  logic [1:0]                        wr_lane,
    input  logic [7:0]                        wr_data,
    input  logic                              rd_en,
    input  logic [$clog2(MAX_COLUMNS)+1:0]    rd_addr,
    output logic [3:0][7:0]                   rd_data,
    output logic                              busy
);

    localparam int AW    = $clog2(MAX_COLUMNS) + 2;
    localparam int DEPTH = 1 << AW;

    // word = one column of rows n, n+4, n+8, n+12 (lane 0..3)
    logic [3:0][7:0] frame_mem [DEPTH];
    logic [3:0][7:0] rd_data_reg;
    logic [AW-1:0]   clr_addr_reg;
    logic [AW-1:0]   clr_addr_next;
    logic            busy_reg;
    logic            busy_next;

    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        busy_next     = busy_reg;
        if (busy_reg)
        begin
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            busy_reg     <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            busy_reg     <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            frame_mem[clr_addr_reg] <= '0;
        end
        else if (wr_en)
        begin
            frame_mem[wr_addr][wr_lane] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= frame_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

// ===== design/slms_scan_seq.sv =====
module slms_scan_seq #(
    parameter int MAX_COLUMNS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  slms_pkg::cfg_t                 cfg,
    output logic [$clog2(MAX_COLUMNS)+1:0] rd_addr,
    output slms_pkg::scan_out_t            scan
);

    localparam int COL_W = $clog2(MAX_COLUMNS);

    typedef enum logic [2:0] {
        PH_ROW_START,
        PH_SHIFT_LOW,
        PH_SHIFT_HIGH,
        PH_LATCH_HIGH,
        PH_LATCH_LOW,
        PH_HOLD
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [1:0]       scan_row_reg, scan_row_next;
    logic [5:0]       shown_reg, shown_next;
    logic [COL_W-1:0] ptr_reg, ptr_next;
    logic [3:0]       bit_reg, bit_next;
    logic [15:0]      hold_reg, hold_next;
    logic [7:0]       fc_reg, fc_next;
    logic [COL_W-1:0] ss_reg, ss_next;

    logic [8:0]  loop_raw;
    logic [8:0]  loop_len;
    logic [8:0]  cols_per_row;
    logic [8:0]  fps;
    phase_t      cur_phase;
    logic [8:0]  cur_ptr;
    logic [5:0]  cur_shown;
    logic [3:0]  cur_bit;
    logic [15:0] cur_hold;
    logic [8:0]  eff_ptr;
    logic [8:0]  ptr_inc;
    logic [6:0]  shown_inc;
    logic [16:0] hold_inc;
    logic [8:0]  fc_inc;
    logic [8:0]  ss_inc;
    logic        end_row;

    // effective register values
    assign loop_raw = (cfg.scroll_length == 7'd0) ? 9'd1 : {2'b00, cfg.scroll_length};
    assign loop_len = (loop_raw > 9'(MAX_COLUMNS)) ? 9'(MAX_COLUMNS) : loop_raw;
    assign cols_per_row = ({2'b00, cfg.show_width} > 9'(MAX_COLUMNS)) ? 9'(MAX_COLUMNS)
                                                                     : {2'b00, cfg.show_width};
    assign fps      = (cfg.frames_per_step == 8'd0) ? 9'd1 : {1'b0, cfg.frames_per_step};

    always_comb
    begin
        // row start folds into the first tick of the row
        cur_phase = phase_reg;
        cur_ptr   = 9'(ptr_reg);
        cur_shown = shown_reg;
        cur_bit   = bit_reg;
        cur_hold  = hold_reg;
        if (phase_reg == PH_ROW_START)
        begin
            cur_ptr   = 9'(ss_reg);
            cur_shown = '0;
            cur_bit   = '0;
            cur_hold  = '0;
            cur_phase = (cols_per_row == 9'd0) ? PH_LATCH_HIGH : PH_SHIFT_LOW;
        end

        eff_ptr   = (cur_ptr >= loop_len) ? 9'd0 : cur_ptr;
        ptr_inc   = eff_ptr + 9'd1;
        shown_inc = {1'b0, cur_shown} + 7'd1;
        hold_inc  = {1'b0, cur_hold} + 17'd1;
        fc_inc    = {1'b0, fc_reg} + 9'd1;
        ss_inc    = 9'(ss_reg) + 9'd1;
        rd_addr   = {scan_row_reg, eff_ptr[COL_W-1:0]};

        phase_next    = cur_phase;
        ptr_next      = cur_ptr[COL_W-1:0];
        shown_next    = cur_shown;
        bit_next      = cur_bit;
        hold_next     = cur_hold;
        fc_next       = fc_reg;
        ss_next       = ss_reg;
        scan_row_next = scan_row_reg;
        end_row       = 1'b0;

        scan.row_address  = scan_row_reg;
        scan.shift        = 1'b0;
        scan.bit_idx      = cur_bit;
        scan.shift_clock  = 1'b0;
        scan.latch        = 1'b0;
        scan.output_blank = 1'b1;
        scan.frame_end    = 1'b0;

        unique case (cur_phase)
            PH_SHIFT_LOW, PH_SHIFT_HIGH:
            begin
                scan.shift = 1'b1;
                ptr_next   = eff_ptr[COL_W-1:0];
                if (cur_phase == PH_SHIFT_LOW)
                begin
                    phase_next = PH_SHIFT_HIGH;
                end
                else
                begin
                    scan.shift_clock = 1'b1;
                    if (cur_bit == slms_pkg::LAST_BIT)
                    begin
                        bit_next   = '0;
                        ptr_next   = (ptr_inc >= loop_len) ? '0 : ptr_inc[COL_W-1:0];
                        shown_next = shown_inc[5:0];
                        phase_next = ({2'b00, shown_inc} >= cols_per_row) ? PH_LATCH_HIGH
                                                                         : PH_SHIFT_LOW;
                    end
                    else
                    begin
                        bit_next   = cur_bit + 4'd1;
                        phase_next = PH_SHIFT_LOW;
                    end
                end
            end
            PH_LATCH_HIGH:
            begin
                scan.latch = 1'b1;
                phase_next = PH_LATCH_LOW;
            end
            PH_LATCH_LOW:
            begin
                hold_next = '0;
                if (cfg.hold_ticks == 16'd0)
                begin
                    end_row = 1'b1;
                end
                else
                begin
                    phase_next = PH_HOLD;
                end
            end
            PH_HOLD:
            begin
                scan.output_blank = 1'b0;
                if (hold_inc >= {1'b0, cfg.hold_ticks})
                begin
                    hold_next = '0;
                    end_row   = 1'b1;
                end
                else
                begin
                    hold_next = hold_inc[15:0];
                end
            end
            default:
            begin
                phase_next = cur_phase;
            end
        endcase

        if (end_row)
        begin
            if (scan_row_reg == slms_pkg::LAST_ROW)
            begin
                scan.frame_end = 1'b1;
                if (fc_inc >= fps)
                begin
                    fc_next = '0;
                    ss_next = (ss_inc >= loop_len) ? '0 : ss_inc[COL_W-1:0];
                end
                else
                begin
                    fc_next = fc_inc[7:0];
                end
            end
            scan_row_next = scan_row_reg + 2'd1;
            phase_next    = PH_ROW_START;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_ROW_START;
            scan_row_reg <= '0;
            shown_reg    <= '0;
            ptr_reg      <= '0;
            bit_reg      <= '0;
            hold_reg     <= '0;
            fc_reg       <= '0;
            ss_reg       <= '0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            scan_row_reg <= scan_row_next;
            shown_reg    <= shown_next;
            ptr_reg      <= ptr_next;
            bit_reg      <= bit_next;
            hold_reg     <= hold_next;
            fc_reg       <= fc_next;
            ss_reg       <= ss_next;
        end
    end

endmodule

// ===== design/scrolling_led_matrix_scanner_unit.sv =====
// Scan driver for a 4-row-multiplexed red LED panel with horizontal scrolling.
// Each cmd item is either a frame buffer write (mode 0, no result) or one scan
// tick (mode 1), which yields exactly one pins item: row address, the upper and
// lower red serial bits, shift clock, latch, output blank and a frame end flag.
// One item is taken per clock while the buffer is not being zeroed and stage p is
// free or moving on. The buffer is read once per tick as the tick is taken, so an
// earlier write is seen. The result then passes two result registers, stage p and
// stage o, so cmd can still take writes and one more tick while a finished pins
// item waits. After reset the frame buffer is zeroed by a sweep of all its
// 4 * 2**ceil(log2(MAX_COLUMNS)) words (256 at the default), during which cmd is
// not ready; configuration writes are taken at any time but belong to idle spans.
module scrolling_led_matrix_scanner_unit #(
    parameter int MAX_COLUMNS = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    slms_in_if.sink                         cmd,
    slms_out_if.source                      pins,
    input  logic                            cfg_write,
    input  logic [1:0]                      cfg_index,
    input  logic [slms_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int COL_W = $clog2(MAX_COLUMNS);
    localparam int AW    = COL_W + 2;

    // configuration registers
    slms_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scroll_length   <= slms_pkg::SCROLL_LENGTH_RST;
            cfg_reg.show_width      <= slms_pkg::SHOW_WIDTH_RST;
            cfg_reg.frames_per_step <= slms_pkg::FRAMES_PER_STEP_RST;
            cfg_reg.hold_ticks      <= slms_pkg::HOLD_TICKS_RST;
        end
        else if (cfg_write)
        begin
            unique case (slms_pkg::reg_index_t'(cfg_index))
                slms_pkg::REG_SCROLL_LENGTH:   cfg_reg.scroll_length   <= cfg_data[6:0];
                slms_pkg::REG_SHOW_WIDTH:      cfg_reg.show_width      <= cfg_data[6:0];
                slms_pkg::REG_FRAMES_PER_STEP: cfg_reg.frames_per_step <= cfg_data[7:0];
                slms_pkg::REG_HOLD_TICKS:      cfg_reg.hold_ticks      <= cfg_data[15:0];
            endcase
        end
    end

    // cmd handshake and item decode
    logic            accept;
    logic            tick_accept;
    logic            wr_accept;
    logic            clear_busy;
    logic            p_advance;
    logic [8:0]      wr_col;
    logic [AW-1:0]   wr_addr;
    logic [AW-1:0]   rd_addr;
    logic [3:0][7:0] rd_data;

    slms_pkg::scan_out_t scan;

    // stage p: tick fields next to the registered buffer word
    logic                p_valid_reg, p_valid_next;
    slms_pkg::scan_out_t p_scan_reg;

    // stage o: pins result register
    logic       o_valid_reg, o_valid_next;
    logic [1:0] o_row_address_reg;
    logic       o_upper_red_reg, o_upper_red_next;
    logic       o_lower_red_reg, o_lower_red_next;
    logic       o_shift_clock_reg;
    logic       o_latch_reg;
    logic       o_output_blank_reg;
    logic       o_frame_end_reg;

    // stage p moves on when the result register is free or being emptied
    assign p_advance   = p_valid_reg && (!o_valid_reg || pins.ready);
    assign cmd.ready   = !clear_busy && (!p_valid_reg || p_advance);
    assign accept      = cmd.valid && cmd.ready;
    assign tick_accept = accept && (cmd.mode == slms_pkg::MODE_TICK);

    // columns past the buffer width are dropped
    assign wr_col    = {3'b000, cmd.buf_column};
    assign wr_accept = accept && (cmd.mode == slms_pkg::MODE_WRITE)
                       && (wr_col < 9'(MAX_COLUMNS));
    assign wr_addr   = {cmd.buf_row[1:0], wr_col[COL_W-1:0]};

    slms_frame_buf #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_frame_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_accept),
        .wr_addr (wr_addr),
        .wr_lane (cmd.buf_row[3:2]),
        .wr_data (cmd.buf_data),
        .rd_en   (tick_accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .busy    (clear_busy)
    );

    slms_scan_seq #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_scan_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (tick_accept),
        .cfg     (cfg_reg),
        .rd_addr (rd_addr),
        .scan    (scan)
    );

    always_comb
    begin
        p_valid_next = p_valid_reg;
        if (tick_accept)
        begin
            p_valid_next = 1'b1;
        end
        else if (p_advance)
        begin
            p_valid_next = 1'b0;
        end

        o_valid_next = o_valid_reg;
        if (p_advance)
        begin
            o_valid_next = 1'b1;
        end
        else if (pins.ready)
        begin
            o_valid_next = 1'b0;
        end

        // lanes: 0 row n, 1 row n+4, 2 row n+8, 3 row n+12
        // bits 0..7 msb first from rows n+4 / n+12, bits 8..15 lsb first from n / n+8
        o_upper_red_next = 1'b0;
        o_lower_red_next = 1'b0;
        if (p_scan_reg.shift)
        begin
            if (!p_scan_reg.bit_idx[3])
            begin
                o_upper_red_next = rd_data[1][~p_scan_reg.bit_idx[2:0]];
                o_lower_red_next = rd_data[3][~p_scan_reg.bit_idx[2:0]];
            end
            else
            begin
                o_upper_red_next = rd_data[0][p_scan_reg.bit_idx[2:0]];
                o_lower_red_next = rd_data[2][p_scan_reg.bit_idx[2:0]];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= p_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_accept)
        begin
            p_scan_reg <= scan;
        end
        if (p_advance)
        begin
            o_row_address_reg  <= p_scan_reg.row_address;
            o_upper_red_reg    <= o_upper_red_next;
            o_lower_red_reg    <= o_lower_red_next;
            o_shift_clock_reg  <= p_scan_reg.shift_clock;
            o_latch_reg        <= p_scan_reg.latch;
            o_output_blank_reg <= p_scan_reg.output_blank;
            o_frame_end_reg    <= p_scan_reg.frame_end;
        end
    end

    assign pins.valid        = o_valid_reg;
    assign pins.row_address  = o_row_address_reg;
    assign pins.upper_red    = o_upper_red_reg;
    assign pins.lower_red    = o_lower_red_reg;
    assign pins.shift_clock  = o_shift_clock_reg;
    assign pins.latch        = o_latch_reg;
    assign pins.output_blank = o_output_blank_reg;
    assign pins.frame_end    = o_frame_end_reg;

    // no item is taken while the buffer is being zeroed
    assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy |-> !cmd.ready)
        else $error("cmd taken during buffer clear");

    // every tick lands in stage p
    assert property (@(posedge clk) disable iff (!rst_n)
        tick_accept |=> p_valid_reg)
        else $error("tick item lost before stage p");

    // a stalled stage p keeps its fields and its buffer word
    assert property (@(posedge clk) disable iff (!rst_n)
        (p_valid_reg && !p_advance) |=> ($stable(p_scan_reg) && $stable(rd_data)))
        else $error("stalled stage p changed");

    // latch ticks keep the panel dark and the shift clock low
    assert property (@(posedge clk) disable iff (!rst_n)
        (p_valid_reg && p_scan_reg.latch) |->
            (p_scan_reg.output_blank && !p_scan_reg.shift_clock))
        else $error("latch tick with panel lit or clock high");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;

    // size of the block under test and of its frame buffer
    localparam int COLS     = 64;
    localparam int BUF_ROWS = 16;

    // width of the configuration data port
    localparam int CFG_W = slms_pkg::CFG_DATA_W;

    // longest wait either side draws before an item
    localparam int MAX_GAP = 7;

    // cycles after the last pin state, enough for write items still in flight
    localparam int DRAIN = 6;

    // ticks for the wide test: the first several columns of a row clamped to 64 columns
    localparam int WIDE_TICKS = 250;

    // where the scan is inside one multiplexed row
    typedef enum logic [2:0] {
        SCAN_ROW_START,
        SCAN_SHIFT_LOW,
        SCAN_SHIFT_HIGH,
        SCAN_LATCH_HIGH,
        SCAN_LATCH_LOW,
        SCAN_HOLD
    } scan_phase_t;

    // pin state of one tick, in the order of the output item
    typedef struct packed {
        logic [1:0] row_address;
        logic       upper_red;
        logic       lower_red;
        logic       shift_clock;
        logic       latch;
        logic       output_blank;
        logic       frame_end;
    } pin_state_t;

    // one register setting and how many random items run under it
    typedef struct {
        int scroll_len;
        int show;
        int fps;
        int hold;
        int count;
    } scan_setting_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_write;
    logic [1:0]       cfg_index;
    logic [CFG_W-1:0] cfg_data;

    slms_in_if  cmd_if ();
    slms_out_if pins_if ();

    scrolling_led_matrix_scanner_unit #(
        .MAX_COLUMNS (COLS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_if),
        .pins      (pins_if),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // scanner state as the testbench sees it
    logic [7:0]     pixels [BUF_ROWS][COLS];
    logic [5:0]     scroll_pos;
    logic [7:0]     frame_cnt;
    logic [1:0]     row_sel;
    logic [5:0]     cols_done;
    logic [5:0]     col_ptr;
    logic [3:0]     bit_pos;
    scan_phase_t    phase;
    logic [15:0]    hold_cnt;
    slms_pkg::cfg_t regs;

    // pin states still owed by the block, oldest first
    pin_state_t pin_states_due [$];

    int mismatches;

    // when set, neither side idles: gives stretches at full rate
    bit calm;

    always #1 clk = ~clk;

    // ---------------------------------------------------------------
    // scan predictor
    // ---------------------------------------------------------------

    task automatic model_reset();
        foreach (pixels[r, c])
            pixels[r][c] = '0;
        scroll_pos = '0;
        frame_cnt  = '0;
        row_sel    = '0;
        cols_done  = '0;
        col_ptr    = '0;
        bit_pos    = '0;
        phase      = SCAN_ROW_START;
        hold_cnt   = '0;
        regs.scroll_length   = slms_pkg::SCROLL_LENGTH_RST;
        regs.show_width      = slms_pkg::SHOW_WIDTH_RST;
        regs.frames_per_step = slms_pkg::FRAMES_PER_STEP_RST;
        regs.hold_ticks      = slms_pkg::HOLD_TICKS_RST;
    endtask

    // loop length, zero acts as one, clamped to the buffer width
    function automatic int loop_cols();
        int v;
        v = regs.scroll_length;
        if (v < 1)
            v = 1;
        if (v > COLS)
            v = COLS;
        return v;
    endfunction

    // columns per row, clamped to the buffer width
    function automatic int show_cols();
        return (regs.show_width > COLS) ? COLS : int'(regs.show_width);
    endfunction

    // step to the next row address; after row 3 count the frame and maybe scroll
    function automatic logic close_row();
        logic last;
        int   step;
        last = (row_sel == slms_pkg::LAST_ROW);
        if (last)
        begin
            step = (regs.frames_per_step == 0) ? 1 : int'(regs.frames_per_step);
            if (frame_cnt + 1 >= step)
            begin
                frame_cnt  = '0;
                scroll_pos = (scroll_pos + 1 >= loop_cols()) ? '0 : scroll_pos + 1'b1;
            end
            else
            begin
                frame_cnt = frame_cnt + 1'b1;
            end
        end
        row_sel = row_sel + 1'b1;
        phase   = SCAN_ROW_START;
        return last;
    endfunction

    // one scan tick: pin state it shows and the state it leaves behind
    task automatic advance_scan(output pin_state_t p);
        int         n;
        int         k;
        int         next_done;
        logic [7:0] upper_byte;
        logic [7:0] lower_byte;
        p = '0;
        p.output_blank = 1'b1;
        // a new row picks up the scroll start and clears its counters
        if (phase == SCAN_ROW_START)
        begin
            col_ptr   = scroll_pos;
            cols_done = '0;
            bit_pos   = '0;
            hold_cnt  = '0;
            phase     = (show_cols() == 0) ? SCAN_LATCH_HIGH : SCAN_SHIFT_LOW;
        end
        n = row_sel;
        p.row_address = row_sel;
        case (phase)
            SCAN_SHIFT_LOW, SCAN_SHIFT_HIGH:
            begin
                k = bit_pos;
                // a pointer past the loop end reads column 0
                if (col_ptr >= loop_cols())
                    col_ptr = '0;
                // first half: rows n+4 and n+12 msb first; second half: rows n and n+8 lsb first
                if (k < 8)
                begin
                    upper_byte  = pixels[n + 4][col_ptr];
                    lower_byte  = pixels[n + 12][col_ptr];
                    p.upper_red = upper_byte[7 - k];
                    p.lower_red = lower_byte[7 - k];
                end
                else
                begin
                    upper_byte  = pixels[n][col_ptr];
                    lower_byte  = pixels[n + 8][col_ptr];
                    p.upper_red = upper_byte[k - 8];
                    p.lower_red = lower_byte[k - 8];
                end
                if (phase == SCAN_SHIFT_LOW)
                begin
                    phase = SCAN_SHIFT_HIGH;
                end
                else
                begin
                    p.shift_clock = 1'b1;
                    if (bit_pos == slms_pkg::LAST_BIT)
                    begin
                        bit_pos   = '0;
                        col_ptr   = (col_ptr + 1 >= loop_cols()) ? '0 : col_ptr + 1'b1;
                        // compare before the count wraps at 64
                        next_done = cols_done + 1;
                        phase     = (next_done >= show_cols()) ? SCAN_LATCH_HIGH
                                                               : SCAN_SHIFT_LOW;
                        cols_done = 6'(next_done);
                    end
                    else
                    begin
                        bit_pos = bit_pos + 1'b1;
                        phase   = SCAN_SHIFT_LOW;
                    end
                end
            end
            SCAN_LATCH_HIGH:
            begin
                p.latch = 1'b1;
                phase   = SCAN_LATCH_LOW;
            end
            SCAN_LATCH_LOW:
            begin
                hold_cnt = '0;
                // no hold time: the row ends right here
                if (regs.hold_ticks == 0)
                    p.frame_end = close_row();
                else
                    phase = SCAN_HOLD;
            end
            default:
            begin
                p.output_blank = 1'b0;
                hold_cnt = hold_cnt + 1'b1;
                // a hold lowered below the count ends the row on this tick
                if (hold_cnt >= regs.hold_ticks)
                begin
                    hold_cnt    = '0;
                    p.frame_end = close_row();
                end
            end
        endcase
    endtask

    // ---------------------------------------------------------------
    // checking
    // ---------------------------------------------------------------

    task automatic compare_pin(string field, logic [1:0] want, logic [1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    // everything is sampled at the rising edge, inputs move at the falling one
    always @(posedge clk)
    begin : monitor
        pin_state_t want;
        pin_state_t got;
        if (rst_n)
        begin
            // pin state leaving the block
            if (pins_if.valid && pins_if.ready)
            begin
                got = '{pins_if.row_address, pins_if.upper_red, pins_if.lower_red,
                        pins_if.shift_clock, pins_if.latch, pins_if.output_blank,
                        pins_if.frame_end};
                if (pin_states_due.size() == 0)
                begin
                    $display("%0t: pin state with none expected, expected none, got %h",
                             $time, got);
                    mismatches++;
                end
                else
                begin
                    want = pin_states_due.pop_front();
                    compare_pin("row_address", want.row_address, got.row_address);
                    compare_pin("upper_red", want.upper_red, got.upper_red);
                    compare_pin("lower_red", want.lower_red, got.lower_red);
                    compare_pin("shift_clock", want.shift_clock, got.shift_clock);
                    compare_pin("latch", want.latch, got.latch);
                    compare_pin("output_blank", want.output_blank, got.output_blank);
                    compare_pin("frame_end", want.frame_end, got.frame_end);
                end
            end
            // register writes, masked to the register width
            if (cfg_write)
            begin
                unique case (slms_pkg::reg_index_t'(cfg_index))
                    slms_pkg::REG_SCROLL_LENGTH:   regs.scroll_length   = cfg_data[6:0];
                    slms_pkg::REG_SHOW_WIDTH:      regs.show_width      = cfg_data[6:0];
                    slms_pkg::REG_FRAMES_PER_STEP: regs.frames_per_step = cfg_data[7:0];
                    slms_pkg::REG_HOLD_TICKS:      regs.hold_ticks      = cfg_data[15:0];
                    default: ;
                endcase
            end
            // item entering the block: buffer write or one tick
            if (cmd_if.valid && cmd_if.ready)
            begin
                if (cmd_if.mode == slms_pkg::MODE_WRITE)
                begin
                    pixels[cmd_if.buf_row][cmd_if.buf_column] = cmd_if.buf_data;
                end
                else
                begin
                    advance_scan(want);
                    pin_states_due.push_back(want);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // pin side: a random stall before every item it takes
    // ---------------------------------------------------------------

    initial
    begin : pin_sink
        int stall;
        pins_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, MAX_GAP);
            // only drop ready when there is a stall, so it never bounces in one step
            if (stall > 0)
            begin
                pins_if.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            pins_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!pins_if.valid);
            @(negedge clk);
        end
    end

    // ---------------------------------------------------------------
    // command side
    // ---------------------------------------------------------------

    // one item: optional gap, then hold it until taken; returns on a falling edge
    task automatic send_item(logic mode, logic [3:0] row, logic [5:0] column,
                             logic [7:0] data);
        int gap;
        gap = calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.mode       <= mode;
        cmd_if.buf_row    <= row;
        cmd_if.buf_column <= column;
        cmd_if.buf_data   <= data;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        @(negedge clk);
    endtask

    task automatic send_tick();
        send_item(slms_pkg::MODE_TICK, 4'($urandom), 6'($urandom), 8'($urandom));
    endtask

    // mostly ticks; writes land mostly in the first columns the short loops read
    task automatic send_random_item(int write_odds);
        if ($urandom_range(0, 39) == 0)
            calm = !calm;
        if ($urandom_range(0, write_odds - 1) == 0)
            send_item(slms_pkg::MODE_WRITE, 4'($urandom),
                      ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7)),
                      8'($urandom));
        else
            send_tick();
    endtask

    // stop sending and wait until every owed pin state is out
    task automatic settle();
        cmd_if.valid <= 1'b0;
        while (pin_states_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    task automatic set_reg(slms_pkg::reg_index_t index, int unsigned value);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= CFG_W'(value);
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    task automatic configure(int scroll_len, int show, int fps, int hold);
        settle();
        set_reg(slms_pkg::REG_SCROLL_LENGTH, scroll_len);
        set_reg(slms_pkg::REG_SHOW_WIDTH, show);
        set_reg(slms_pkg::REG_FRAMES_PER_STEP, fps);
        set_reg(slms_pkg::REG_HOLD_TICKS, hold);
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // corner rows, columns and data values; rows 0, 4, 8 and 12 of column 0 feed row address 0
    task automatic test_buffer_edges();
        send_item(slms_pkg::MODE_WRITE, 4'd0, 6'd0, 8'hFF);
        send_item(slms_pkg::MODE_WRITE, 4'd15, 6'd63, 8'h80);
        send_item(slms_pkg::MODE_WRITE, 4'd4, 6'd0, 8'h01);
        send_item(slms_pkg::MODE_WRITE, 4'd12, 6'd0, 8'hA5);
        send_item(slms_pkg::MODE_WRITE, 4'd8, 6'd0, 8'h3C);
        send_item(slms_pkg::MODE_WRITE, 4'd15, 6'd0, 8'h00);
        send_item(slms_pkg::MODE_WRITE, 4'd0, 6'd63, 8'h7E);
    endtask

    // first shift ticks under the reset register values
    task automatic test_reset_scan();
        repeat (10) send_tick();
    endtask

    // rewrite row 4 while its bits are going out: the later bits show the new byte
    task automatic test_mid_column_write();
        send_item(slms_pkg::MODE_WRITE, 4'd4, 6'd0, 8'hF0);
        repeat (8) send_tick();
    endtask

    // random items under a run of settings, extremes and out-of-range values among them
    task automatic test_register_sweep();
        scan_setting_t plan [8] = '{
            '{64, 0, 1, 0, 40},       // no columns, no hold: short frames, fast scrolling
            '{4, 2, 1, 0, 40},        // scroll start left beyond a shorter loop
            '{0, 3, 2, 1, 40},        // zero loop length acts as one column
            '{127, 2, 0, 3, 40},      // loop above range, zero frames per step
            '{5, 1, 255, 0, 40},      // slowest scrolling
            '{6, 1, 3, 65535, 60},    // longest hold, entered but not waited out
            '{6, 1, 3, 5, 40},        // hold lowered below the running count
            '{2, 4, 1, 2, 40}         // shown width above loop length, columns repeat
        };
        foreach (plan[i])
        begin
            configure(plan[i].scroll_len, plan[i].show, plan[i].fps, plan[i].hold);
            repeat (plan[i].count) send_random_item(5);
        end
    endtask

    // widest row: a width above range acts as 64 columns, the row is left partway
    task automatic test_full_width();
        int tick_count;
        configure(COLS, 127, 1, 0);
        tick_count = 0;
        while (tick_count < WIDE_TICKS)
        begin
            if ($urandom_range(0, 39) == 0)
                calm = !calm;
            if ($urandom_range(0, 15) == 0)
            begin
                send_item(slms_pkg::MODE_WRITE, 4'($urandom), 6'($urandom), 8'($urandom));
            end
            else
            begin
                send_tick();
                tick_count++;
            end
        end
    endtask

    // ---------------------------------------------------------------
    // run
    // ---------------------------------------------------------------

    initial
    begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        cmd_if.valid      = 1'b0;
        cmd_if.mode       = slms_pkg::MODE_WRITE;
        cmd_if.buf_row    = '0;
        cmd_if.buf_column = '0;
        cmd_if.buf_data   = '0;
        cfg_write         = 1'b0;
        cfg_index         = slms_pkg::REG_SCROLL_LENGTH;
        cfg_data          = '0;
        calm              = 1'b0;
        mismatches        = 0;
        model_reset();
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // the buffer clearing sweep after reset just holds off the first item
        test_buffer_edges();
        test_reset_scan();
        test_mid_column_write();
        test_register_sweep();
        test_full_width();

        settle();
        if (mismatches == 0 && pin_states_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial
    begin
        #1_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
